/* design/mktd_pkg.sv */
// Package for the Morse key timing decoder.
// Holds the widths, reset values, timing thresholds and the Morse code table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mktd_pkg;

  localparam int MAX_SYMBOLS = 5;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 2);
  localparam int GAP_W       = 20;
  localparam int DOT_W       = 16;
  localparam int CHAR_W      = 7;
  localparam int CODE_COUNT  = 36;

  localparam logic [GAP_W-1:0]  GAP_MAX      = {GAP_W{1'b1}};
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd45;  // '-'
  localparam logic [DOT_W-1:0]  DOT_RESET    = 16'd1000;

  // Thresholds at reset dot time: dash above 3 dots, char gap above 4,
  // word gap at 10 or more.
  localparam logic [GAP_W-1:0] THR3_RESET  = GAP_W'(DOT_RESET * 3);
  localparam logic [GAP_W-1:0] THR4_RESET  = GAP_W'(DOT_RESET * 4);
  localparam logic [GAP_W-1:0] THR10_RESET = GAP_W'(DOT_RESET * 10);

  typedef struct packed {
    logic [CNT_W-1:0]       len;
    logic [MAX_SYMBOLS-1:0] pattern;  // first symbol in bit 0, 1 = dash
    logic [CHAR_W-1:0]      ch;
  } code_entry_t;

  localparam code_entry_t CODE_TABLE [CODE_COUNT] = '{
    '{3'd2, 5'h02, 7'd65}, '{3'd4, 5'h01, 7'd66}, '{3'd4, 5'h05, 7'd67},
    '{3'd3, 5'h01, 7'd68}, '{3'd1, 5'h00, 7'd69}, '{3'd4, 5'h04, 7'd70},
    '{3'd3, 5'h03, 7'd71}, '{3'd4, 5'h00, 7'd72}, '{3'd2, 5'h00, 7'd73},
    '{3'd4, 5'h0E, 7'd74}, '{3'd3, 5'h05, 7'd75}, '{3'd4, 5'h02, 7'd76},
    '{3'd2, 5'h03, 7'd77}, '{3'd2, 5'h01, 7'd78}, '{3'd3, 5'h07, 7'd79},
    '{3'd4, 5'h06, 7'd80}, '{3'd4, 5'h0B, 7'd81}, '{3'd3, 5'h02, 7'd82},
    '{3'd3, 5'h00, 7'd83}, '{3'd1, 5'h01, 7'd84}, '{3'd3, 5'h04, 7'd85},
    '{3'd4, 5'h08, 7'd86}, '{3'd3, 5'h06, 7'd87}, '{3'd4, 5'h09, 7'd88},
    '{3'd4, 5'h0D, 7'd89}, '{3'd4, 5'h03, 7'd90},
    '{3'd5, 5'h1F, 7'd48}, '{3'd5, 5'h1E, 7'd49}, '{3'd5, 5'h1C, 7'd50},
    '{3'd5, 5'h18, 7'd51}, '{3'd5, 5'h10, 7'd52}, '{3'd5, 5'h00, 7'd53},
    '{3'd5, 5'h01, 7'd54}, '{3'd5, 5'h03, 7'd55}, '{3'd5, 5'h07, 7'd56},
    '{3'd5, 5'h0F, 7'd57}
  };

endpackage

`default_nettype wire

/* design/mktd_code_lut.sv */
// Morse code to ASCII lookup, combinational.
// Depends on mktd_pkg (code table, widths).
`timescale 1ns / 1ps
`default_nettype none

module mktd_code_lut
  import mktd_pkg::*;
(
  input  wire logic [CNT_W-1:0]       sym_count,
  input  wire logic [MAX_SYMBOLS-1:0] sym_bits,
  output logic      [CHAR_W-1:0]      char_code
);

  always_comb begin
    char_code = CHAR_UNKNOWN;
    // empty or overflowed codes stay '-'
    if (sym_count != '0 && sym_count <= CNT_W'(MAX_SYMBOLS)) begin
      for (int i = 0; i < CODE_COUNT; i++) begin
        if (CODE_TABLE[i].len == sym_count && CODE_TABLE[i].pattern == sym_bits) begin
          char_code = CODE_TABLE[i].ch;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/morse_key_timing_decoder.sv */
// Top level of the Morse key timing decoder.
// Depends on mktd_pkg and mktd_code_lut.
// Channels: in_valid / in_stall / in_key_down carry one key sample per
//   transaction, normally one each tick. out_valid / out_stall /
//   out_char_code / out_word_end carry one decoded character per transaction;
//   a sample yields at most one, on a key press after a gap over 4 dot times.
//   cfg_wr_en / cfg_wr_data write the dot time in ticks; write only while
//   the block is idle. Thresholds (3, 4 and 10 dot times) are computed then.
// Timing: one sample per cycle sustained while in_stall is low. A character
//   goes into the output register, or into the skid register when the
//   output entry is held; the whole update (saturating gap count, threshold
//   compares, table lookup) runs from the key state registers to the buffer.
// Reset: synchronous, active low. Key released, gap count and symbols
//   cleared, dot time 1000 ticks, output empty.
// Back pressure: a two-entry output buffer (output register plus skid
//   register) lets a sample be taken while a character waits. in_stall
//   rises only when both entries hold characters.
`timescale 1ns / 1ps
`default_nettype none

module morse_key_timing_decoder
  import mktd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [DOT_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_key_down,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] out_char_code,
  output logic                   out_word_end
);

  // thresholds in ticks
  logic [GAP_W-1:0] thr3_r, thr4_r, thr10_r;

  // key tracking state
  logic                   key_was_down_r, key_was_down_nxt;
  logic [GAP_W-1:0]       gap_r, gap_nxt;
  logic [MAX_SYMBOLS-1:0] sym_bits_r, sym_bits_nxt;
  logic [CNT_W-1:0]       sym_count_r, sym_count_nxt;

  // output buffer
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt, skid_char_r, skid_char_nxt;
  logic              out_word_r, out_word_nxt, skid_word_r, skid_word_nxt;

  logic              accept;
  logic              press, release_key;
  logic              emit;
  logic              word_end;
  logic [GAP_W-1:0]  len;
  logic [CHAR_W-1:0] lut_char;
  logic              pop;

  assign in_stall      = skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_word_end  = out_word_r;

  assign accept      = in_valid && !in_stall;
  assign press       = in_key_down && !key_was_down_r;
  assign release_key = !in_key_down && key_was_down_r;
  // gap count saturates; the incremented value is the measured length
  assign len         = (gap_r == GAP_MAX) ? gap_r : gap_r + GAP_W'(1);
  assign emit        = accept && press && (len > thr4_r);
  assign word_end    = (len >= thr10_r);
  assign pop         = out_valid_r && !out_stall;

  mktd_code_lut u_code_lut (
    .sym_count (sym_count_r),
    .sym_bits  (sym_bits_r),
    .char_code (lut_char)
  );

  // key state update
  always_comb begin
    key_was_down_nxt = key_was_down_r;
    gap_nxt          = gap_r;
    sym_bits_nxt     = sym_bits_r;
    sym_count_nxt    = sym_count_r;
    if (accept) begin
      gap_nxt = len;
      if (press) begin
        if (len > thr4_r) begin
          sym_bits_nxt  = '0;
          sym_count_nxt = '0;
        end
        key_was_down_nxt = 1'b1;
        gap_nxt          = '0;
      end else if (release_key) begin
        if (sym_count_r < CNT_W'(MAX_SYMBOLS)) begin
          for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (sym_count_r == CNT_W'(i) && len > thr3_r) begin
              sym_bits_nxt[i] = 1'b1;
            end
          end
          sym_count_nxt = sym_count_r + CNT_W'(1);
        end else begin
          sym_count_nxt = CNT_W'(MAX_SYMBOLS + 1);  // overflow mark
        end
        key_was_down_nxt = 1'b0;
        gap_nxt          = '0;
      end
    end
  end

  // two-entry output buffer, kept in order
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_char_nxt   = out_char_r;
    out_word_nxt   = out_word_r;
    skid_char_nxt  = skid_char_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = skid_char_r;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = emit;
        skid_char_nxt  = lut_char;
        skid_word_nxt  = word_end;
      end else begin
        out_valid_nxt = emit;
        out_char_nxt  = lut_char;
        out_word_nxt  = word_end;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_char_nxt  = lut_char;
      skid_word_nxt  = word_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr3_r         <= THR3_RESET;
      thr4_r         <= THR4_RESET;
      thr10_r        <= THR10_RESET;
      key_was_down_r <= 1'b0;
      gap_r          <= '0;
      sym_bits_r     <= '0;
      sym_count_r    <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr3_r  <= GAP_W'({cfg_wr_data, 1'b0}) + GAP_W'(cfg_wr_data);
        thr4_r  <= GAP_W'({cfg_wr_data, 2'b00});
        thr10_r <= GAP_W'({cfg_wr_data, 3'b000}) + GAP_W'({cfg_wr_data, 1'b0});
      end
      key_was_down_r <= key_was_down_nxt;
      gap_r          <= gap_nxt;
      sym_bits_r     <= sym_bits_nxt;
      sym_count_r    <= sym_count_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_char_r  <= out_char_nxt;
    out_word_r  <= out_word_nxt;
    skid_char_r <= skid_char_nxt;
    skid_word_r <= skid_word_nxt;
  end

  // skid entry only fills behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // symbol count never passes the overflow mark
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sym_count_r <= CNT_W'(MAX_SYMBOLS + 1))
    else $error("symbol count beyond overflow mark");

  // a taken press restarts the gap count with the key held down
  a_press_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && press) |=> (gap_r == '0 && key_was_down_r))
    else $error("gap count not restarted on key press");

  // a stalled character is not lost
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled character dropped");

endmodule

`default_nettype wire
